[rtl/bds_pkg.sv]
// ----------------------------------------------------------------------------
// bds_pkg
// Shared types and constants for the bigram Dice similarity block.
// ----------------------------------------------------------------------------
package bds_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned BIGRAM_W = 16;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SIM_W    = 17;
  localparam int unsigned MATCH_W  = 8;
  localparam int unsigned TOTAL_W  = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [SIM_W-1:0]  THRESHOLD_RESET = 17'd49152;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND_FIRST  = 2'd0,
    CMD_APPEND_SECOND = 2'd1,
    CMD_COMPARE       = 2'd2,
    CMD_UNUSED        = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPACE_SENSITIVE = 2'd0,
    REG_CASE_SENSITIVE  = 2'd1,
    REG_THRESHOLD       = 2'd2,
    REG_NONE            = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_LOAD,
    ST_OUTER,
    ST_INNER,
    ST_DIVIDE,
    ST_CLEAR,
    ST_RESULT
  } state_t;

  // Lower-case folding of A..Z, unless exact is set
  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                  input logic exact);
    logic [CHAR_W-1:0] r;
    r = c;
    if (!exact && c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
    return r;
  endfunction

endpackage

[rtl/bds_if.sv]
// ----------------------------------------------------------------------------
// bds_if
// Handshake channels: input items, result items and register writes.
// ----------------------------------------------------------------------------
interface bds_in_if;
  logic                      valid;
  logic                      ready;
  logic [bds_pkg::CMD_W-1:0]  command;
  logic [bds_pkg::CHAR_W-1:0] character;
  modport source (output valid, command, character, input ready);
  modport sink   (input valid, command, character, output ready);
endinterface

interface bds_out_if;
  logic                       valid;
  logic                       ready;
  logic [bds_pkg::MATCH_W-1:0] match_count;
  logic [bds_pkg::TOTAL_W-1:0] bigram_total;
  logic [bds_pkg::SIM_W-1:0]   similarity;
  logic                       above_threshold;
  logic                       overflow;
  modport source (output valid, match_count, bigram_total, similarity,
                  above_threshold, overflow, input ready);
  modport sink   (input valid, match_count, bigram_total, similarity,
                  above_threshold, overflow, output ready);
endinterface

interface bds_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bds_pkg::CFG_IDX_W-1:0]  index;
  logic [bds_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/bds_ram.sv]
// ----------------------------------------------------------------------------
// bds_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bds_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[rtl/bds_div.sv]
// ----------------------------------------------------------------------------
// bds_div
// Restoring divider, one quotient bit a cycle: (2*matches << 16) / total.
// ----------------------------------------------------------------------------
module bds_div #(
  parameter int unsigned NUM_W = 26,
  parameter int unsigned DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem;
  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;

  assign trial = {rem[DEN_W-1:0], q[NUM_W-1]};
  assign quot  = q;

  // One shift and subtract a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= numer;
        d    <= denom;
        rem  <= '0;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q   <= {q[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/bigram_dice_similarity.sv]
// ----------------------------------------------------------------------------
// bigram_dice_similarity
// Sorensen-Dice similarity of two lines held as character bigrams.
// ----------------------------------------------------------------------------
// Append commands are taken one per cycle while the block is loading, so
// characters stream in back to back. After reset the used-bit memory is
// cleared with the input held off. A compare walks the stores: for every
// first-line bigram it scans the second-line store through one RAM read port
// until an unused match is found, then runs a serial divide (skipped when
// both lines are empty), then a clearing pass over the used-bit memory,
// before the result is offered. No input is taken from a compare until its
// result has been transferred. Registers are written through the
// configuration channel; the user must write them only while the block is
// idle, as the block itself does not enforce this.
module bigram_dice_similarity #(
  parameter int unsigned MAX_LINE = 256
) (
  input logic  clk,
  input logic  rst,
  bds_in_if.sink    in_ch,
  bds_out_if.source out_ch,
  bds_cfg_if.sink   cfg_ch
);

  localparam int unsigned AW  = $clog2(MAX_LINE);
  localparam int unsigned CW  = $clog2(MAX_LINE + 1);
  localparam int unsigned TW  = CW + 1;
  localparam int unsigned NUM_W = CW + bds_pkg::SIM_W;

  // Configuration registers
  logic                      keep_spaces, exact_case;
  logic [bds_pkg::SIM_W-1:0] threshold;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_spaces <= 1'b0;
      exact_case  <= 1'b0;
      threshold   <= bds_pkg::THRESHOLD_RESET;
    end else if (cfg_ch.valid) begin
      unique case (bds_pkg::reg_idx_t'(cfg_ch.index))
        bds_pkg::REG_SPACE_SENSITIVE: keep_spaces <= cfg_ch.data[0];
        bds_pkg::REG_CASE_SENSITIVE:  exact_case  <= cfg_ch.data[0];
        bds_pkg::REG_THRESHOLD:       threshold   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Control state
  bds_pkg::state_t state, state_next;
  logic [CW-1:0] first_count, second_count, run_len;
  logic [bds_pkg::CHAR_W-1:0] previous_char;
  logic dropped_flag, active_line;
  logic [CW-1:0] i_idx, j_idx;
  logic          rd_pending;
  logic [CW-1:0] match_cnt;
  logic [AW-1:0] clr_idx;

  // Memories
  logic          f_we, s_we, u_we;
  logic [AW-1:0] f_waddr, s_waddr, u_waddr, f_raddr, s_raddr;
  logic [bds_pkg::BIGRAM_W-1:0] bigram, f_rdata, s_rdata;
  logic          u_wdata, u_rdata;

  bds_ram #(.WIDTH(bds_pkg::BIGRAM_W), .DEPTH(MAX_LINE)) u_first (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(bigram), .raddr(f_raddr),
    .rdata(f_rdata));
  bds_ram #(.WIDTH(bds_pkg::BIGRAM_W), .DEPTH(MAX_LINE)) u_second (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(bigram), .raddr(s_raddr),
    .rdata(s_rdata));
  bds_ram #(.WIDTH(1), .DEPTH(MAX_LINE)) u_used (
    .clk, .we(u_we), .waddr(u_waddr), .wdata(u_wdata), .raddr(s_raddr),
    .rdata(u_rdata));

  // Append path
  logic in_fire, is_append, line_sel, same_line, has_space, keep, room;
  logic [CW-1:0] len_eff, cnt_sel;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign is_append = (in_ch.command == bds_pkg::CMD_APPEND_FIRST) ||
                     (in_ch.command == bds_pkg::CMD_APPEND_SECOND);
  assign line_sel  = in_ch.command[0];
  assign same_line = (line_sel == active_line);
  assign len_eff   = same_line ? run_len : '0;
  assign cnt_sel   = line_sel ? second_count : first_count;
  assign has_space = (previous_char == bds_pkg::SPACE_CHAR) ||
                     (in_ch.character == bds_pkg::SPACE_CHAR);
  assign keep      = (len_eff != '0) && (keep_spaces || !has_space);
  assign room      = cnt_sel < CW'(MAX_LINE - 1);
  assign bigram    = {bds_pkg::fold_char(previous_char, exact_case),
                      bds_pkg::fold_char(in_ch.character, exact_case)};

  logic app_ok;
  assign app_ok  = in_fire && is_append && (len_eff < CW'(MAX_LINE));
  assign f_we    = app_ok && keep && room && !line_sel;
  assign s_we    = app_ok && keep && room && line_sel;
  assign f_waddr = first_count[AW-1:0];
  assign s_waddr = second_count[AW-1:0];

  assign in_ch.ready = (state == bds_pkg::ST_LOAD);

  // Compare walk addresses
  assign f_raddr = i_idx[AW-1:0];
  assign s_raddr = j_idx[AW-1:0];

  logic hit;
  assign hit = rd_pending && !u_rdata && (s_rdata == f_rdata);

  always_comb begin
    u_we    = 1'b0;
    u_waddr = clr_idx;
    u_wdata = 1'b0;
    if (state == bds_pkg::ST_CLEAR || state == bds_pkg::ST_INIT) begin
      u_we = 1'b1;
    end else if (state == bds_pkg::ST_INNER && hit) begin
      u_we    = 1'b1;
      u_waddr = s_raddr - AW'(1);
      u_wdata = 1'b1;
    end
  end

  // Divider
  logic          div_start, div_done;
  logic [NUM_W-1:0] div_q;
  logic [TW-1:0] total;
  assign total = TW'(first_count) + TW'(second_count);

  bds_div #(.NUM_W(NUM_W), .DEN_W(TW)) u_div (
    .clk, .rst, .start(div_start),
    .numer({match_cnt, {bds_pkg::SIM_W{1'b0}}}),
    .denom(total), .done(div_done), .quot(div_q));

  // Next state
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      bds_pkg::ST_INIT:
        if (clr_idx == AW'(MAX_LINE - 1)) state_next = bds_pkg::ST_LOAD;
      bds_pkg::ST_LOAD:
        if (in_fire && in_ch.command == bds_pkg::CMD_COMPARE)
          state_next = bds_pkg::ST_OUTER;
      bds_pkg::ST_OUTER:
        if (i_idx >= first_count || second_count == '0) begin
          state_next = bds_pkg::ST_DIVIDE;
          div_start  = (total != '0);
        end else begin
          state_next = bds_pkg::ST_INNER;
        end
      bds_pkg::ST_INNER:
        if (hit || (rd_pending && j_idx >= second_count))
          state_next = bds_pkg::ST_OUTER;
      bds_pkg::ST_DIVIDE:
        if (total == '0 || div_done) state_next = bds_pkg::ST_CLEAR;
      bds_pkg::ST_CLEAR:
        if (clr_idx == AW'(MAX_LINE - 1)) state_next = bds_pkg::ST_RESULT;
      bds_pkg::ST_RESULT:
        if (out_ch.ready) state_next = bds_pkg::ST_LOAD;
      default: state_next = bds_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bds_pkg::ST_INIT;
    else     state <= state_next;
  end

  // Datapath registers
  logic [bds_pkg::SIM_W-1:0] sim;
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count   <= '0;
      second_count  <= '0;
      run_len       <= '0;
      previous_char <= '0;
      dropped_flag  <= 1'b0;
      active_line   <= 1'b0;
      i_idx         <= '0;
      j_idx         <= '0;
      rd_pending    <= 1'b0;
      match_cnt     <= '0;
      clr_idx       <= '0;
    end else begin
      unique case (state)
        bds_pkg::ST_INIT: begin
          clr_idx <= clr_idx + 1'b1;
        end
        bds_pkg::ST_LOAD: begin
          match_cnt <= '0;
          i_idx     <= '0;
          clr_idx   <= '0;
          if (in_fire && is_append) begin
            active_line <= line_sel;
            if (len_eff >= CW'(MAX_LINE)) begin
              dropped_flag <= 1'b1;
              run_len      <= len_eff;
            end else begin
              if (keep && !room) dropped_flag <= 1'b1;
              if (f_we) first_count  <= first_count + 1'b1;
              if (s_we) second_count <= second_count + 1'b1;
              previous_char <= in_ch.character;
              run_len       <= len_eff + 1'b1;
            end
          end
        end
        bds_pkg::ST_OUTER: begin
          j_idx      <= '0;
          rd_pending <= 1'b0;
        end
        bds_pkg::ST_INNER: begin
          // Address j is issued, data arrives next cycle
          rd_pending <= (j_idx < second_count);
          j_idx      <= j_idx + 1'b1;
          if (hit) match_cnt <= match_cnt + 1'b1;
          if (hit || (rd_pending && j_idx >= second_count)) i_idx <= i_idx + 1'b1;
          if (j_idx >= second_count) rd_pending <= 1'b0;
        end
        bds_pkg::ST_DIVIDE: ;
        bds_pkg::ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
        end
        bds_pkg::ST_RESULT:
          if (out_ch.ready) begin
            first_count   <= '0;
            second_count  <= '0;
            run_len       <= '0;
            previous_char <= '0;
            dropped_flag  <= 1'b0;
            active_line   <= 1'b0;
          end
        default: ;
      endcase
    end
  end

  // Quotient capture
  always_ff @(posedge clk) begin
    if (state == bds_pkg::ST_OUTER) sim <= '0;
    else if (div_done) sim <= div_q[bds_pkg::SIM_W-1:0];
  end

  assign out_ch.valid           = (state == bds_pkg::ST_RESULT);
  assign out_ch.match_count     = bds_pkg::MATCH_W'(match_cnt);
  assign out_ch.bigram_total    = bds_pkg::TOTAL_W'(total);
  assign out_ch.similarity      = sim;
  assign out_ch.above_threshold = (sim > threshold);
  assign out_ch.overflow        = dropped_flag;

endmodule

[rtl/bds_checker.sv]
// ----------------------------------------------------------------------------
// bds_checker
// Port-level checks of the similarity block, bound to the top level.
// ----------------------------------------------------------------------------
module bds_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [bds_pkg::CMD_W-1:0]   in_command,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [bds_pkg::TOTAL_W-1:0] bigram_total,
  input logic [bds_pkg::SIM_W-1:0]   similarity
);

  // Result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(similarity))
    else $error("result changed while stalled");

  // No input taken while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready with result pending");

  // Zero total gives zero ratio
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bigram_total == '0 |-> similarity == '0)
    else $error("nonzero ratio for empty input");

  // Ratio never exceeds one
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> similarity <= 17'd65536)
    else $error("ratio out of range");

  // Compare stops intake next cycle
  a_cmp: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_command == bds_pkg::CMD_COMPARE |=> !in_ready)
    else $error("intake after compare");

endmodule

bind bigram_dice_similarity bds_checker u_bds_checker (
  .clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_command(in_ch.command),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .bigram_total(out_ch.bigram_total),
  .similarity(out_ch.similarity));
